// File: hw/rtl/tse_pkg.sv
// Package for the tween slot engine: sizes, opcodes, curve codes.
// Used by tween_slot_engine; no dependencies.
`timescale 1ns / 1ps
package tse_pkg;
    localparam int TSE_POOL_SLOTS = 16;
    localparam int TSE_FRAC_BITS  = 16;
    localparam logic [31:0] MIN_LENGTH = 32'd7;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    localparam logic [2:0] EASE_LINEAR    = 3'd0;
    localparam logic [2:0] EASE_QUAD_IN   = 3'd1;
    localparam logic [2:0] EASE_QUAD_OUT  = 3'd2;
    localparam logic [2:0] EASE_QUAD_IO   = 3'd3;
    localparam logic [2:0] EASE_CUBIC_IN  = 3'd4;
    localparam logic [2:0] EASE_CUBIC_OUT = 3'd5;
    localparam logic [2:0] EASE_CUBIC_IO  = 3'd6;
endpackage

// File: hw/rtl/tween_slot_engine.sv
// Tween slot engine top level: slot pool, sequencer, shared divider and multiplier.
// Depends on tse_pkg.
//
//  channel | direction | handshake       | payload
//  in      | input     | in_valid/stall  | opcode .. time_step
//  out     | output    | out_valid/stall | kind .. last
//
// Start hunts upward for the lowest free slot, then sends its reply; cancel ends
// in its accept cycle.
// A tick walks every slot: an idle slot is skipped, a slot that finishes is read
// and output, and a running slot is read, divided ((32+FRAC_BITS)-bit dividend),
// eased, blended and output; the walk then closes. Output stalls can hold any output step.
// Reset clears slot valid bits and generations and sets the generation counter to 1.
// Input stall is high whenever an item is in work.
`timescale 1ns / 1ps
module tween_slot_engine
    import tse_pkg::*;
#(
    parameter int POOL_SLOTS = TSE_POOL_SLOTS,
    parameter int FRAC_BITS  = TSE_FRAC_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         opcode,
    input  logic [15:0]        target_tag,
    input  logic signed [31:0] start_value,
    input  logic signed [31:0] end_value,
    input  logic [31:0]        duration,
    input  logic [2:0]         easing_mode,
    input  logic [31:0]        handle,
    input  logic [31:0]        time_step,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               kind,
    output logic [31:0]        result_handle,
    output logic [15:0]        result_tag,
    output logic signed [31:0] value,
    output logic               finished,
    output logic               last
);
    localparam int IW  = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int CW  = $clog2(POOL_SLOTS + 1);
    localparam int NW  = 32 + FRAC_BITS;           // dividend width
    localparam int SW  = $clog2(NW + 1);
    localparam logic [FRAC_BITS+2:0] ONE = (FRAC_BITS+3)'(1) << FRAC_BITS;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_READ  = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_BLEND = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;

    // slot storage
    logic [POOL_SLOTS-1:0] active_reg;
    logic [15:0] gen_reg [POOL_SLOTS];
    logic [15:0] tag_mem [POOL_SLOTS];
    logic [31:0] start_mem [POOL_SLOTS];
    logic [31:0] end_mem [POOL_SLOTS];
    logic [31:0] len_mem [POOL_SLOTS];
    logic [31:0] el_mem [POOL_SLOTS];
    logic [2:0]  curve_mem [POOL_SLOTS];
    logic [15:0] next_gen_reg;

    logic [3:0]    state_reg;
    logic [15:0]   itag_reg;
    logic [31:0]   istart_reg, iend_reg, idur_reg, dt_reg;
    logic [2:0]    imode_reg;
    logic [CW-1:0] idx_reg;
    logic          found_reg;

    // per-slot working registers
    logic [31:0]   s_el_reg, s_len_reg, s_start_reg, s_end_reg;
    logic [15:0]   s_tag_reg, s_gen_reg;
    logic [2:0]    s_curve_reg;
    logic [NW-1:0] quo_reg;
    logic [32:0]   rem_reg;
    logic [SW-1:0] step_reg;
    logic [2:0]    mstep_reg;
    logic [FRAC_BITS+2:0] t_reg, e_reg, acc_reg;
    logic signed [32:0] diff_reg;
    logic signed [33+FRAC_BITS+2:0] prod_reg;

    // output register
    logic        ov_reg, okind_reg, ofin_reg, olast_reg;
    logic [31:0] oh_reg, oval_reg;
    logic [15:0] otag_reg;
    logic        emitted_reg;

    // tick word held back until the next one or the end of the walk
    logic [31:0] hold_h_reg, hold_val_reg;
    logic [15:0] hold_tag_reg;
    logic        hold_fin_reg;

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = ov_reg;
    assign kind          = okind_reg;
    assign result_handle = oh_reg;
    assign result_tag    = otag_reg;
    assign value         = oval_reg;
    assign finished      = ofin_reg;
    assign last          = olast_reg;

    logic in_acc, out_free;
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !ov_reg || !out_stall;

    logic [IW-1:0] idx;
    assign idx = idx_reg[IW-1:0];

    // elapsed after this tick, saturating
    logic [32:0] el_sum;
    logic [31:0] el_new;
    assign el_sum = {1'b0, el_mem[idx]} + {1'b0, dt_reg};
    assign el_new = el_sum[32] ? 32'hFFFF_FFFF : el_sum[31:0];

    // one restoring divide step
    logic [32:0] rem_shift, rem_sub;
    assign rem_shift = {rem_reg[31:0], quo_reg[NW-1]};
    assign rem_sub   = rem_shift - {1'b0, s_len_reg};

    // shared multiplier: operands chosen by curve and by which half t lies in
    logic [FRAC_BITS+2:0] ma, mb;
    logic [2*(FRAC_BITS+3)-1:0] mp;
    logic [FRAC_BITS+2:0] mq;
    assign mp = ma * mb;
    assign mq = (FRAC_BITS+3)'(mp >> FRAC_BITS);

    logic t_lo;
    logic [FRAC_BITS+2:0] f_base;
    assign t_lo = t_reg < (ONE >> 1);
    always_comb
    begin
        f_base = t_reg;
        case (s_curve_reg)
            EASE_QUAD_OUT:  f_base = (ONE << 1) - t_reg;
            EASE_QUAD_IO:   f_base = t_lo ? (t_reg << 1) : ((ONE << 2) - (t_reg << 1));
            EASE_CUBIC_OUT: f_base = ONE - t_reg;
            EASE_CUBIC_IO:  f_base = t_lo ? (t_reg << 2) : ((ONE << 1) - (t_reg << 1));
            default:        f_base = t_reg;
        endcase
    end

    always_comb
    begin
        ma = acc_reg;
        mb = t_reg;
        if (s_curve_reg == EASE_CUBIC_OUT ||
            (s_curve_reg == EASE_CUBIC_IO && !t_lo))
        begin
            mb = f_base;
        end
    end

    // how many multiplies the curve needs
    logic [2:0] mcount;
    always_comb
    begin
        case (s_curve_reg)
            EASE_QUAD_IN, EASE_QUAD_OUT, EASE_QUAD_IO: mcount = 3'd1;
            EASE_CUBIC_IN, EASE_CUBIC_OUT, EASE_CUBIC_IO: mcount = 3'd2;
            default: mcount = 3'd0;
        endcase
    end

    // final eased value from the last product
    logic [FRAC_BITS+2:0] ease_fin;
    always_comb
    begin
        case (s_curve_reg)
            EASE_QUAD_IO:   ease_fin = t_lo ? acc_reg : acc_reg - ONE;
            EASE_CUBIC_OUT: ease_fin = ONE - acc_reg;
            EASE_CUBIC_IO:  ease_fin = t_lo ? acc_reg : ONE - (acc_reg >> 1);
            default:        ease_fin = acc_reg;
        endcase
    end

    // blend: floor of signed product
    logic signed [33+FRAC_BITS+2:0] bprod;
    logic signed [33+FRAC_BITS+2:0] bq;
    logic [31:0] bval;
    assign bprod = diff_reg * $signed({1'b0, e_reg});
    assign bq    = prod_reg >>> FRAC_BITS;
    assign bval  = s_start_reg + bq[31:0];

    logic [CW-1:0] idx_inc;
    assign idx_inc = idx_reg + CW'(1);
    logic [15:0] h_idx;
    assign h_idx = 16'(idx_reg);

    // load the output register when a word leaves the sequencer
    logic ov_set;
    always_comb
    begin
        case (state_reg)
            S_EMIT:  ov_set = out_free;
            S_OUT:   ov_set = emitted_reg && out_free;
            S_SCAN:  ov_set = (idx_reg == CW'(POOL_SLOTS)) && emitted_reg && out_free;
            default: ov_set = 1'b0;
        endcase
    end

    // sequencer and storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            active_reg   <= '0;
            next_gen_reg <= 16'd1;
            ov_reg       <= 1'b0;
            emitted_reg  <= 1'b0;
            for (int k = 0; k < POOL_SLOTS; k++)
            begin
                gen_reg[k] <= 16'd0;
            end
        end
        else
        begin
            ov_reg <= ov_set || (ov_reg && out_stall);
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        itag_reg    <= target_tag;
                        istart_reg  <= start_value;
                        iend_reg    <= end_value;
                        idur_reg    <= duration;
                        imode_reg   <= easing_mode;
                        dt_reg      <= time_step;
                        idx_reg     <= '0;
                        found_reg   <= 1'b0;
                        emitted_reg <= 1'b0;
                        if (opcode == OP_START)
                        begin
                            state_reg <= S_START;
                        end
                        else if (opcode == OP_CANCEL)
                        begin
                            if (handle != 32'd0 && {16'd0, handle[15:0]} < 32'(POOL_SLOTS)
                                && active_reg[handle[IW-1:0]]
                                && gen_reg[handle[IW-1:0]] == handle[31:16])
                            begin
                                active_reg[handle[IW-1:0]] <= 1'b0;
                            end
                        end
                        else if (opcode == OP_TICK && time_step != 32'd0)
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                // hunt lowest free slot, one per cycle
                S_START:
                begin
                    if (idx_reg == CW'(POOL_SLOTS))
                    begin
                        state_reg <= S_EMIT;
                    end
                    else if (!active_reg[idx])
                    begin
                        tag_mem[idx]   <= itag_reg;
                        start_mem[idx] <= istart_reg;
                        end_mem[idx]   <= iend_reg;
                        len_mem[idx]   <= (idur_reg < MIN_LENGTH) ? MIN_LENGTH : idur_reg;
                        el_mem[idx]    <= 32'd0;
                        curve_mem[idx] <= imode_reg;
                        gen_reg[idx]   <= next_gen_reg;
                        next_gen_reg   <= (next_gen_reg == 16'hFFFF) ? 16'd1
                                                                     : next_gen_reg + 16'd1;
                        active_reg[idx] <= 1'b1;
                        s_gen_reg      <= next_gen_reg;
                        found_reg      <= 1'b1;
                        state_reg      <= S_EMIT;
                    end
                    else
                    begin
                        idx_reg <= idx_inc;
                    end
                end
                // send start reply
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        okind_reg <= 1'b0;
                        oh_reg    <= found_reg ? {s_gen_reg, h_idx} : 32'd0;
                        otag_reg  <= itag_reg;
                        oval_reg  <= 32'd0;
                        ofin_reg  <= 1'b0;
                        olast_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                // walk slots; release the held word with last set at the end
                S_SCAN:
                begin
                    if (idx_reg == CW'(POOL_SLOTS))
                    begin
                        if (!emitted_reg || out_free)
                        begin
                            if (emitted_reg)
                            begin
                                okind_reg <= 1'b1;
                                oh_reg    <= hold_h_reg;
                                otag_reg  <= hold_tag_reg;
                                oval_reg  <= hold_val_reg;
                                ofin_reg  <= hold_fin_reg;
                                olast_reg <= 1'b1;
                            end
                            state_reg <= S_IDLE;
                        end
                    end
                    else if (active_reg[idx])
                    begin
                        state_reg <= S_READ;
                    end
                    else
                    begin
                        idx_reg <= idx_inc;
                    end
                end
                S_READ:
                begin
                    el_mem[idx]  <= el_new;
                    s_el_reg     <= el_new;
                    s_len_reg    <= len_mem[idx];
                    s_start_reg  <= start_mem[idx];
                    s_end_reg    <= end_mem[idx];
                    s_tag_reg    <= tag_mem[idx];
                    s_gen_reg    <= gen_reg[idx];
                    s_curve_reg  <= curve_mem[idx];
                    quo_reg      <= {el_new, FRAC_BITS'(0)};
                    rem_reg      <= '0;
                    step_reg     <= '0;
                    if (el_new >= len_mem[idx])
                    begin
                        active_reg[idx] <= 1'b0;
                        state_reg       <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                // restoring divide, one quotient bit a cycle
                S_DIV:
                begin
                    if (rem_sub[32])
                    begin
                        rem_reg <= rem_shift;
                        quo_reg <= {quo_reg[NW-2:0], 1'b0};
                    end
                    else
                    begin
                        rem_reg <= rem_sub;
                        quo_reg <= {quo_reg[NW-2:0], 1'b1};
                    end
                    step_reg <= step_reg + SW'(1);
                    if (step_reg == SW'(NW - 1))
                    begin
                        state_reg <= S_MUL;
                        mstep_reg <= '0;
                    end
                end
                // shared multiplier steps for the easing curve
                S_MUL:
                begin
                    if (mstep_reg == 3'd0)
                    begin
                        t_reg     <= quo_reg[FRAC_BITS+2:0];
                        mstep_reg <= 3'd1;
                    end
                    else if (mstep_reg == 3'd1)
                    begin
                        acc_reg   <= f_base;
                        mstep_reg <= 3'd2;
                    end
                    else if (mstep_reg < 3'd2 + mcount)
                    begin
                        acc_reg   <= mq;
                        mstep_reg <= mstep_reg + 3'd1;
                    end
                    else
                    begin
                        e_reg     <= ease_fin;
                        diff_reg  <= $signed({s_end_reg[31], s_end_reg})
                                     - $signed({s_start_reg[31], s_start_reg});
                        state_reg <= S_BLEND;
                        mstep_reg <= 3'd0;
                    end
                end
                S_BLEND:
                begin
                    prod_reg  <= bprod;
                    state_reg <= S_OUT;
                end
                // pass the held word on, hold this slot's word
                S_OUT:
                begin
                    if (!emitted_reg || out_free)
                    begin
                        if (emitted_reg)
                        begin
                            okind_reg <= 1'b1;
                            oh_reg    <= hold_h_reg;
                            otag_reg  <= hold_tag_reg;
                            oval_reg  <= hold_val_reg;
                            ofin_reg  <= hold_fin_reg;
                            olast_reg <= 1'b0;
                        end
                        hold_h_reg   <= {s_gen_reg, h_idx};
                        hold_tag_reg <= s_tag_reg;
                        hold_fin_reg <= (s_el_reg >= s_len_reg);
                        hold_val_reg <= (s_el_reg >= s_len_reg) ? s_end_reg : bval;
                        emitted_reg  <= 1'b1;
                        idx_reg      <= idx_inc;
                        state_reg    <= S_SCAN;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    property p_busy_stall;
        @(posedge clk) disable iff (!rst_n) (state_reg != S_IDLE) |-> in_stall;
    endproperty
    a_busy_stall: assert property (p_busy_stall) else $error("busy but not stalled");

    property p_gen_nonzero;
        @(posedge clk) disable iff (!rst_n) next_gen_reg != 16'd0;
    endproperty
    a_gen_nonzero: assert property (p_gen_nonzero) else $error("generation zero");

    property p_start_last;
        @(posedge clk) disable iff (!rst_n) (out_valid && !kind) |-> last;
    endproperty
    a_start_last: assert property (p_start_last) else $error("start reply without last");

    property p_div_bound;
        @(posedge clk) disable iff (!rst_n) (state_reg == S_DIV) |-> (rem_reg < {1'b0, s_len_reg});
    endproperty
    a_div_bound: assert property (p_div_bound) else $error("divider remainder overflow");
endmodule
